@@ hw/rtl/frpd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// frpd_pkg
// Shared field widths, opcodes and the control word passed to each rule cell
// of the first-rule pattern dispatcher.
// ----------------------------------------------------------------------------
package frpd_pkg;

    localparam int OP_W       = 2;
    localparam int BYTE_W     = 8;
    localparam int RULE_IDX_W = 3;
    localparam int POS_W      = 4;
    localparam int LEN_W      = 5;
    localparam int TAG_W      = 32;
    localparam int COUNT_W    = 4;

    localparam logic [OP_W-1:0] OP_DATA  = 2'd0;
    localparam logic [OP_W-1:0] OP_END   = 2'd1;
    localparam logic [OP_W-1:0] OP_WBYTE = 2'd2;
    localparam logic [OP_W-1:0] OP_WRULE = 2'd3;

    typedef struct packed {
        logic              data_en;
        logic              clear;
        logic              byte_we;
        logic              rule_we;
        logic [POS_W-1:0]  byte_pos;
        logic [BYTE_W-1:0] wdata;
        logic [LEN_W-1:0]  plen;
        logic [TAG_W-1:0]  tag;
    } cell_ctl_t;

endpackage
`default_nettype wire

@@ hw/rtl/frpd_rule_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// frpd_rule_cell
// One rule slot: pattern bytes, length, tag and sticky hit flag. Compares the
// pattern against the newest bytes of the history window on every data word.
// ----------------------------------------------------------------------------
module frpd_rule_cell
    import frpd_pkg::*;
#(
    parameter int MAX_PATTERN_LEN = 16,
    localparam int CNT_W = $clog2(MAX_PATTERN_LEN + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_ctl_t         ctl,
    input  logic [BYTE_W-1:0] window_next [MAX_PATTERN_LEN],
    input  logic [CNT_W-1:0]  bytes_seen_next,
    output logic              done_hit,
    output logic [TAG_W-1:0]  tag
);

    localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int IDX_W = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;

    logic [BYTE_W-1:0]          pattern_reg [MAX_PATTERN_LEN];
    logic [LEN_W-1:0]           length_reg;
    logic [TAG_W-1:0]           tag_reg;
    logic                       hit_reg;
    logic                       hit_next;
    logic [CMP_W-1:0]           sel [MAX_PATTERN_LEN];
    logic [BYTE_W-1:0]          aligned [MAX_PATTERN_LEN];
    logic [MAX_PATTERN_LEN-1:0] byte_ok;
    logic                       match_now;
    logic [CMP_W-1:0]           len_ext;

    assign len_ext = CMP_W'(length_reg);

    // align window bytes so that pattern byte k meets window entry len-1-k
    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN_LEN; k++)
        begin
            sel[k] = len_ext - CMP_W'(1) - CMP_W'(k);
            if (sel[k] < CMP_W'(MAX_PATTERN_LEN))
            begin
                aligned[k] = window_next[sel[k][IDX_W-1:0]];
            end
            else
            begin
                aligned[k] = '0;
            end
            byte_ok[k] = (CMP_W'(k) >= len_ext) || (pattern_reg[k] == aligned[k]);
        end
    end

    assign match_now = (length_reg != '0)
                    && (len_ext <= CMP_W'(MAX_PATTERN_LEN))
                    && (len_ext <= CMP_W'(bytes_seen_next))
                    && (&byte_ok);

    always_comb
    begin
        hit_next = hit_reg;
        if (ctl.clear)
        begin
            hit_next = 1'b0;
        end
        else if (ctl.data_en && match_now)
        begin
            hit_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg    <= 1'b0;
            length_reg <= '0;
        end
        else
        begin
            hit_reg <= hit_next;
            if (ctl.rule_we)
            begin
                length_reg <= ctl.plen;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rule_we)
        begin
            tag_reg <= ctl.tag;
        end
        for (int k = 0; k < MAX_PATTERN_LEN; k++)
        begin
            if (ctl.byte_we && (32'(ctl.byte_pos) == k))
            begin
                pattern_reg[k] <= ctl.wdata;
            end
        end
    end

    assign done_hit = (length_reg == '0) || hit_reg;
    assign tag      = tag_reg;

endmodule
`default_nettype wire

@@ hw/rtl/first_rule_pattern_dispatch.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// first_rule_pattern_dispatch
// Streams bytes past a table of byte patterns and reports, per end word, the
// tag of the lowest-numbered active rule whose pattern occurred.
// ----------------------------------------------------------------------------
// Two register stages: an input register and a result register, with all
// rules compared in parallel against the history window in between. One word
// is taken every clock cycle while the input is not stalled; a result is
// written into the result register when its end word leaves the input
// register. The only stall towards the input comes from an end word that
// finds the result register still full and stalled. Rule table loads travel
// through the input channel; the active rule count is written on cfg_we.
// ----------------------------------------------------------------------------
module first_rule_pattern_dispatch
    import frpd_pkg::*;
#(
    parameter int RULES           = 8,
    parameter int MAX_PATTERN_LEN = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [OP_W-1:0]       opcode,
    input  logic [BYTE_W-1:0]     data_byte,
    input  logic [RULE_IDX_W-1:0] rule_index,
    input  logic [POS_W-1:0]      byte_position,
    input  logic [LEN_W-1:0]      pattern_length,
    input  logic [TAG_W-1:0]      rule_tag_in,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  matched,
    output logic [TAG_W-1:0]      match_tag,

    input  logic                  cfg_we,
    input  logic [COUNT_W-1:0]    cfg_wdata
);

    localparam int CNT_W = $clog2(MAX_PATTERN_LEN + 1);

    logic                  s1_valid_reg;
    logic [OP_W-1:0]       s1_op_reg;
    logic [BYTE_W-1:0]     s1_byte_reg;
    logic [RULE_IDX_W-1:0] s1_idx_reg;
    logic [POS_W-1:0]      s1_pos_reg;
    logic [LEN_W-1:0]      s1_len_reg;
    logic [TAG_W-1:0]      s1_tag_reg;
    logic                  s1_adv;
    logic                  in_take;

    logic [BYTE_W-1:0]     window_reg  [MAX_PATTERN_LEN];
    logic [BYTE_W-1:0]     window_next [MAX_PATTERN_LEN];
    logic [CNT_W-1:0]      bytes_seen_reg;
    logic [CNT_W-1:0]      bytes_seen_next;
    logic [COUNT_W-1:0]    rule_count_reg;

    logic                  is_data;
    logic                  is_end;
    logic                  is_wbyte;
    logic                  is_wrule;

    cell_ctl_t             cell_ctl [RULES];
    logic [RULES-1:0]      cell_done;
    logic [TAG_W-1:0]      cell_tag [RULES];

    logic                  found;
    logic [TAG_W-1:0]      found_tag;

    logic                  out_valid_reg;
    logic                  matched_reg;
    logic [TAG_W-1:0]      match_tag_reg;

    // input register
    assign s1_adv   = s1_valid_reg && ((s1_op_reg != OP_END) || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_op_reg   <= opcode;
            s1_byte_reg <= data_byte;
            s1_idx_reg  <= rule_index;
            s1_pos_reg  <= byte_position;
            s1_len_reg  <= pattern_length;
            s1_tag_reg  <= rule_tag_in;
        end
    end

    // opcode decode
    always_comb
    begin
        is_data  = 1'b0;
        is_end   = 1'b0;
        is_wbyte = 1'b0;
        is_wrule = 1'b0;
        unique case (s1_op_reg)
            OP_DATA:  is_data  = s1_adv;
            OP_END:   is_end   = s1_adv;
            OP_WBYTE: is_wbyte = s1_adv;
            OP_WRULE: is_wrule = s1_adv;
            default:  is_data  = 1'b0;
        endcase
    end

    // history window, newest byte at entry 0
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN_LEN; i++)
        begin
            window_next[i] = window_reg[i];
        end
        bytes_seen_next = bytes_seen_reg;
        if (is_end)
        begin
            for (int i = 0; i < MAX_PATTERN_LEN; i++)
            begin
                window_next[i] = '0;
            end
            bytes_seen_next = '0;
        end
        else if (is_data)
        begin
            window_next[0] = s1_byte_reg;
            for (int i = 1; i < MAX_PATTERN_LEN; i++)
            begin
                window_next[i] = window_reg[i-1];
            end
            if (bytes_seen_reg != CNT_W'(MAX_PATTERN_LEN))
            begin
                bytes_seen_next = bytes_seen_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PATTERN_LEN; i++)
            begin
                window_reg[i] <= '0;
            end
            bytes_seen_reg <= '0;
            rule_count_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < MAX_PATTERN_LEN; i++)
            begin
                window_reg[i] <= window_next[i];
            end
            bytes_seen_reg <= bytes_seen_next;
            if (cfg_we)
            begin
                rule_count_reg <= cfg_wdata;
            end
        end
    end

    // rule cells
    for (genvar r = 0; r < RULES; r++)
    begin : g_rule
        logic sel;

        assign sel = (32'(s1_idx_reg) == r);

        always_comb
        begin
            cell_ctl[r].data_en  = is_data;
            cell_ctl[r].clear    = is_end;
            cell_ctl[r].byte_we  = is_wbyte && sel;
            cell_ctl[r].rule_we  = is_wrule && sel;
            cell_ctl[r].byte_pos = s1_pos_reg;
            cell_ctl[r].wdata    = s1_byte_reg;
            cell_ctl[r].plen     = s1_len_reg;
            cell_ctl[r].tag      = s1_tag_reg;
        end

        frpd_rule_cell #(
            .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
        ) u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .ctl             (cell_ctl[r]),
            .window_next     (window_next),
            .bytes_seen_next (bytes_seen_next),
            .done_hit        (cell_done[r]),
            .tag             (cell_tag[r])
        );
    end

    // lowest-numbered active rule wins
    always_comb
    begin
        found     = 1'b0;
        found_tag = '0;
        for (int r = RULES - 1; r >= 0; r--)
        begin
            if (cell_done[r] && (32'(rule_count_reg) > r))
            begin
                found     = 1'b1;
                found_tag = cell_tag[r];
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (is_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_end)
        begin
            matched_reg   <= found;
            match_tag_reg <= found_tag;
        end
    end

    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;
    assign match_tag = match_tag_reg;

    // checks
    a_tag_zero_when_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (matched_reg || (match_tag_reg == '0)))
        else $error("nonzero tag without a match");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && (s1_op_reg == OP_END) && out_valid_reg && out_stall))
        else $error("input stalled without a blocked end word");

    a_end_clears_stream: assert property (@(posedge clk) disable iff (!rst_n)
        is_end |=> (bytes_seen_reg == '0))
        else $error("stream state not cleared after end word");

endmodule
`default_nettype wire
